[src/lkv_pkg.sv]
`default_nettype none
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int DATA_W      = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  // request kinds
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } lkv_result_t;

endpackage
`default_nettype wire

[src/lkv_array.sv]
`default_nettype none
module lkv_array #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        fire,
  input  wire                        is_put,
  input  wire  [lkv_pkg::DATA_W-1:0] key,
  input  wire  [lkv_pkg::DATA_W-1:0] value,
  input  wire  [CNT_W-1:0]           cap_eff,
  output lkv_pkg::lkv_result_t       result
);
  import lkv_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [DATA_W-1:0]  key_r   [ENTRIES];
  logic [DATA_W-1:0]  value_r [ENTRIES];
  logic [RANK_W-1:0]  rank_r  [ENTRIES];
  logic [RANK_W-1:0]  rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [ENTRIES-1:0] hit_vec, free_oh, victim_oh, target_oh;
  logic [RANK_W-1:0]  victim_rank, target_rank;
  logic [DATA_W-1:0]  hit_value;
  logic               any_hit, evict, touch, target_was_valid, do_write;

  assign victim_rank = RANK_W'(count_r - CNT_W'(1));
  // lowest clear bit of the valid vector
  assign free_oh     = ~valid_r & (valid_r + ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (key_r[i] == key);
      victim_oh[i] = valid_r[i] && (rank_r[i] == victim_rank);
    end
  end

  assign any_hit   = |hit_vec;
  assign evict     = (count_r >= cap_eff);
  assign target_oh = any_hit ? hit_vec : (evict ? victim_oh : free_oh);
  assign touch     = fire && (any_hit || is_put == REQ_PUT);
  assign do_write  = fire && is_put == REQ_PUT;
  assign target_was_valid = |(target_oh & valid_r);

  always_comb begin
    hit_value   = '0;
    target_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value   = hit_value | (hit_vec[i] ? value_r[i] : '0);
      target_rank = target_rank | (target_oh[i] ? rank_r[i] : '0);
    end
  end

  // age every valid entry younger than the touched one; a fresh slot ages all
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (touch) begin
        if (target_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (!target_was_valid || rank_r[i] < target_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (do_write && !any_hit) begin
      valid_nxt = valid_r | target_oh;
      if (!evict) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_write && target_oh[i]) begin
        key_r[i]   <= key;
        value_r[i] <= value;
      end
    end
  end

  always_comb begin
    result.hit = any_hit;
    if (is_put == REQ_PUT) begin
      result.read_value = PUT_VALUE;
    end else if (any_hit) begin
      result.read_value = hit_value;
    end else begin
      result.read_value = MISS_VALUE;
    end
  end

`ifndef SYNTH
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid marks");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_target_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    touch |-> $onehot(target_oh))
    else $error("no single entry selected for update");

  a_put_leaves_entry: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> (valid_r != '0))
    else $error("put left the store empty");
`endif

endmodule
`default_nettype wire

[src/lru_key_value_cache_core.sv]
`default_nettype none
// Fully associative key/value cache with least-recently-used replacement.
// Each input item is a get (tuser 0) or a put (tuser 1) with a 32-bit key and
// value; each produces exactly one result item: tuser is 1 when the key was
// present, tdata holds the stored value on a get hit, all ones on a get miss
// and zero for a put. Items are taken one per cycle while the result side
// keeps up: one input register, then a single pass of parallel key compares
// and rank update into the result register. The capacity register (reset 16,
// zero acts as 1, values above ENTRIES act as ENTRIES) may be written only
// while no item is in flight; lowering it drops nothing at once, later inserts
// evict the oldest entry instead. Valid marks and ranks clear at reset.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [63:0]                in_tdata,   // req_key[31:0], req_value[63:32]
  input  wire                        in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [31:0]                out_tdata,  // read_value[31:0]
  output logic                       out_tuser,  // hit
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [lkv_pkg::CAP_W-1:0]  cfg_data    // capacity
);
  import lkv_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0]  capacity_r;
  logic [CNT_W-1:0]  cap_eff;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_put_r;
  logic [DATA_W-1:0] s1_key_r, s1_value_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_value_r;
  logic              advance, fire, in_accept;
  lkv_result_t       result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity_r) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_put_r   <= in_tuser;
      s1_key_r   <= in_tdata[31:0];
      s1_value_r <= in_tdata[63:32];
    end
    if (fire) begin
      out_hit_r   <= result.hit;
      out_value_r <= result.read_value;
    end
  end

  lkv_array #(
    .ENTRIES (ENTRIES),
    .CNT_W   (CNT_W)
  ) u_array (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .is_put  (s1_put_r),
    .key     (s1_key_r),
    .value   (s1_value_r),
    .cap_eff (cap_eff),
    .result  (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_hit_r;

endmodule
`default_nettype wire
